FILE: rtl/assert_macros.svh
// Assertion macros for the top level of the channel hopper.
// No dependencies; each macro expects clk in scope, RDCH_ASSERT also rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RDCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RDCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rdch_pkg.sv
// Types and constants for the RSSI dwell channel hopper.
// No dependencies; imported by rdch_core and the top level.
package rdch_pkg;

  // Operation codes carried by an input beat
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_LINGER    = 2'd1;
  localparam logic [1:0] REG_COUNT     = 2'd2;

  localparam logic signed [8:0] THRESHOLD_RST = -9'sd140;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_PAUSED = 2'd2,
    MODE_LINGER = 2'd3
  } mode_t;

  // One result beat
  typedef struct packed {
    logic       hopped;
    logic [4:0] channel_index;
    mode_t      mode;
  } result_t;

endpackage

FILE: rtl/rdch_core.sv
// Scanner state, configuration registers and the per-item update.
// Depends on rdch_pkg.
module rdch_core import rdch_pkg::*; #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              accept,
  input  logic [2:0]        operation,
  input  logic signed [8:0] rssi,
  output result_t           res
);

  // channel_count is 6 bits, so the list never exceeds 63 entries
  localparam int LEN_MAX = (MAX_CHANNELS < 63) ? MAX_CHANNELS : 63;
  localparam int IDX_W   = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;

  logic signed [8:0] threshold;
  logic [15:0]       linger_ticks;
  logic [5:0]        channel_count;

  mode_t             mode, mode_next;
  logic [IDX_W-1:0]  index, index_next;
  logic [15:0]       linger_left, linger_left_next;

  logic [5:0]        list_len;
  logic              advance;
  logic [IDX_W:0]    index_inc;
  logic [IDX_W+4:0]  index_ext;

  // Clamp the list length to the hardware limit
  always_comb begin
    if (channel_count > 6'(LEN_MAX)) begin
      list_len = 6'(LEN_MAX);
    end else begin
      list_len = channel_count;
    end
  end

  assign index_inc = {1'b0, index} + 1'b1;

  // Per-item update
  always_comb begin
    mode_next        = mode;
    index_next       = index;
    linger_left_next = linger_left;
    advance          = 1'b0;
    unique case (operation)
      OP_TICK: begin
        if (list_len != 6'd0) begin
          if (mode == MODE_LINGER) begin
            if (linger_left != 16'd0) begin
              linger_left_next = linger_left - 16'd1;
            end else begin
              advance = 1'b1;
            end
          end else if (mode == MODE_RUN) begin
            if (rssi > threshold) begin
              linger_left_next = linger_ticks;
              mode_next        = MODE_LINGER;
            end else begin
              advance = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        if (list_len != 6'd0) begin
          mode_next        = MODE_RUN;
          index_next       = '0;
          linger_left_next = 16'd0;
        end
      end
      OP_STOP: begin
        mode_next        = MODE_OFF;
        linger_left_next = 16'd0;
      end
      OP_PAUSE: begin
        if (mode == MODE_RUN || mode == MODE_LINGER) begin
          mode_next = MODE_PAUSED;
        end
      end
      OP_RESUME: begin
        if (mode == MODE_PAUSED) begin
          mode_next = MODE_RUN;
        end
      end
      default: ;
    endcase
    // Hop with wrap at the list length
    if (advance) begin
      if (7'(index_inc) >= 7'(list_len)) begin
        index_next = '0;
      end else begin
        index_next = index_inc[IDX_W-1:0];
      end
      mode_next = MODE_RUN;
    end
  end

  assign index_ext = {5'd0, index_next};

  assign res.hopped        = advance;
  assign res.channel_index = index_ext[4:0];
  assign res.mode          = mode_next;

  // State and config registers; a real register write clears the index
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      linger_ticks  <= 16'd0;
      channel_count <= 6'd0;
      mode          <= MODE_OFF;
      index         <= '0;
      linger_left   <= 16'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: begin
          threshold <= cfg_data[8:0];
          index     <= '0;
        end
        REG_LINGER: begin
          linger_ticks <= cfg_data;
          index        <= '0;
        end
        REG_COUNT: begin
          channel_count <= cfg_data[5:0];
          index         <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      mode        <= mode_next;
      index       <= index_next;
      linger_left <= linger_left_next;
    end
  end

endmodule

FILE: rtl/rssi_dwell_channel_hopper.sv
// A result beat is written to the output buffer when its input beat is accepted.
// Throughput: one item per cycle; the state update is a single registered pass,
// and a two-entry output buffer keeps input accepted while a result waits.
// Input stalls only when both buffer entries hold untaken results.
// Reset (synchronous, active high): mode off, index 0, linger count 0,
// threshold -140, linger ticks 0, channel count 0, output buffer empty.
`include "assert_macros.svh"

module rssi_dwell_channel_hopper import rdch_pkg::*; #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  logic signed [8:0] rssi,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hopped,
  output logic [4:0]        channel_index,
  output logic [1:0]        mode
);

  result_t    res;
  result_t    buf_mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;
  result_t    head;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  rdch_core #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (push),
    .operation (operation),
    .rssi      (rssi),
    .res       (res)
  );

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= res;
    end
  end

  // Output buffer pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head          = buf_mem[rd_ptr];
  assign hopped        = head.hopped;
  assign channel_index = head.channel_index;
  assign mode          = head.mode;

  // Checks
  `RDCH_ASSERT_ALWAYS(a_count_range, rst || count != 2'd3, "output buffer overfilled")
  `RDCH_ASSERT(a_push_fill, push && !pop |=> count == $past(count) + 2'd1, "fill level lost a push")
  `RDCH_ASSERT(a_hop_runs, out_valid && hopped |-> mode == MODE_RUN, "hop result not in running mode")
  `RDCH_ASSERT(a_ptr_match, count == 2'd0 || count == 2'd2 |-> wr_ptr == rd_ptr, "buffer pointers out of step")

endmodule

FILE: bench/rssi_dwell_channel_hopper_test.sv
// Self-checking bench for the RSSI dwell channel hopper: directed and random beats,
// with a scoreboard class that predicts every result. Depends on rdch_pkg and the RTL.
`timescale 1ns / 1ps

module rssi_dwell_channel_hopper_test;
  import rdch_pkg::*;

  // Register index with no register behind it; reserved operation codes
  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int SEGS_PER_PHASE = 5;
  localparam int BEATS_PER_SEG  = 70;

  // Scanner state tracker and queue of results still due from the block
  class hop_tracker;
    localparam int LIST_MAX = 32;
    logic signed [8:0] threshold;
    logic [15:0]       dwell_ticks;
    logic [5:0]        chan_count;
    mode_t             cur_mode;
    logic [4:0]        cur_index;
    logic [15:0]       dwell_left;
    result_t           due[$];
    int errors, checked, hops, wraps, lingers;

    function new();
      threshold   = THRESHOLD_RST;
      dwell_ticks = '0;
      chan_count  = '0;
      cur_mode    = MODE_OFF;
      cur_index   = '0;
      dwell_left  = '0;
      errors = 0; checked = 0; hops = 0; wraps = 0; lingers = 0;
    endfunction

    // Register write; any real register clears the index
    function void apply_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_THRESHOLD: begin
          threshold = data[8:0];
          cur_index = '0;
        end
        REG_LINGER: begin
          dwell_ticks = data;
          cur_index   = '0;
        end
        REG_COUNT: begin
          chan_count = data[5:0];
          cur_index  = '0;
        end
        default: ;
      endcase
    endfunction

    // Accepted input beat: advance the scanner and queue the result it gives
    function void apply_op(logic [2:0] op, logic signed [8:0] level);
      int      len;
      bit      hop;
      result_t r;
      len = (chan_count > LIST_MAX) ? LIST_MAX : int'(chan_count);
      hop = 1'b0;
      case (op)
        OP_TICK: begin
          if (len != 0) begin
            if (cur_mode == MODE_LINGER) begin
              if (dwell_left != 0) dwell_left--;
              else hop = 1'b1;
            end else if (cur_mode == MODE_RUN) begin
              if (level > threshold) begin
                dwell_left = dwell_ticks;
                cur_mode   = MODE_LINGER;
                lingers++;
              end else begin
                hop = 1'b1;
              end
            end
          end
        end
        OP_START: begin
          if (len != 0) begin
            cur_mode   = MODE_RUN;
            cur_index  = '0;
            dwell_left = '0;
          end
        end
        OP_STOP: begin
          cur_mode   = MODE_OFF;
          dwell_left = '0;
        end
        OP_PAUSE: begin
          if (cur_mode == MODE_RUN || cur_mode == MODE_LINGER) cur_mode = MODE_PAUSED;
        end
        OP_RESUME: begin
          if (cur_mode == MODE_PAUSED) cur_mode = MODE_RUN;
        end
        default: ;
      endcase
      if (hop) begin
        hops++;
        if (int'(cur_index) + 1 >= len) begin
          cur_index = '0;
          wraps++;
        end else begin
          cur_index++;
        end
        cur_mode = MODE_RUN;
      end
      r.hopped        = hop;
      r.channel_index = cur_index;
      r.mode          = cur_mode;
      due.push_back(r);
    endfunction

    // Result beat taken from the block: compare with the oldest due result
    function void match_result(logic h, logic [4:0] ci, logic [1:0] m);
      result_t want;
      if (due.size() == 0) begin
        $error("result beat with none due: hopped %0d index %0d mode %0d", h, ci, m);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (h !== want.hopped) begin
        $error("hopped: expected %0d, got %0d", want.hopped, h);
        errors++;
      end
      if (ci !== want.channel_index) begin
        $error("channel_index: expected %0d, got %0d", want.channel_index, ci);
        errors++;
      end
      if (m !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, m);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        operation = OP_TICK;
  logic signed [8:0] rssi = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hopped;
  logic [4:0]        channel_index;
  logic [1:0]        mode;

  hop_tracker tracker = new();
  int tx_idle = 0;
  int rx_stall = 0;
  int beats_sent = 0;

  rssi_dwell_channel_hopper i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .rssi(rssi),
    .out_valid(out_valid), .out_ready(out_ready),
    .hopped(hopped), .channel_index(channel_index), .mode(mode)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit far above the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: check taken beats, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.match_result(hopped, channel_index, mode);
    out_ready <= ($urandom_range(99) >= rx_stall);
  end

  // One input beat; valid stays up into the next beat unless a gap is drawn
  task automatic send_beat(input logic [2:0] op, input logic signed [8:0] level);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    rssi      <= level;
    do @(posedge clk); while (!in_ready);
    tracker.apply_op(op, level);
    beats_sent++;
  endtask

  // Hold off input until every due result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.apply_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // RSSI: often close to the threshold so both sides of the compare show up
  function automatic logic signed [8:0] pick_level(input logic signed [8:0] thr);
    int v;
    if ($urandom_range(99) < 40) begin
      v = int'(thr) + int'($urandom_range(4)) - 2;
      if (v > 255) v = 255;
      if (v < -256) v = -256;
      return v[8:0];
    end
    return 9'($urandom);
  endfunction

  // Mostly sensible command flow, with some noise
  function automatic logic [2:0] pick_op(input int tick_pct, input mode_t now);
    int r;
    r = $urandom_range(99);
    if (now == MODE_OFF && r < 50) return OP_START;
    if (now == MODE_PAUSED && r < 40) return OP_RESUME;
    if ($urandom_range(99) < tick_pct) return OP_TICK;
    r = $urandom_range(99);
    if (r < 25) return OP_START;
    if (r < 45) return OP_STOP;
    if (r < 70) return OP_PAUSE;
    if (r < 90) return OP_RESUME;
    return 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
  endfunction

  initial begin
    logic signed [8:0] thr;
    logic [15:0]       dwell;
    logic [5:0]        cnt;
    int                tick_pct;
    int                waited;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list after reset: only stop, pause and resume may act
    send_beat(OP_TICK, 9'sd255);
    send_beat(OP_START, '0);
    send_beat(OP_PAUSE, '0);
    send_beat(OP_RESUME, '0);
    send_beat(OP_STOP, '0);
    send_beat(OP_RSVD_LO, -9'sd256);
    send_beat(OP_RSVD_HI, '0);
    drain();
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'h0000);
    write_reg(REG_LINGER, 16'd0);
    write_reg(REG_COUNT, 16'd3);
    end_writes();

    // Three channels, threshold 0, no extra linger ticks
    send_beat(OP_START, '0);
    send_beat(OP_TICK, -9'sd256);   // weak: hop
    send_beat(OP_TICK, 9'sd255);    // strong: linger
    send_beat(OP_TICK, '0);         // zero linger: hop right away
    send_beat(OP_TICK, '0);         // equal to threshold: hop and wrap
    send_beat(OP_TICK, 9'sd1);
    send_beat(OP_PAUSE, '0);
    send_beat(OP_TICK, 9'sd200);    // paused: ignored
    send_beat(OP_RESUME, '0);
    send_beat(OP_RESUME, '0);       // not paused: ignored
    send_beat(OP_TICK, 9'sd1);
    send_beat(OP_STOP, '0);
    send_beat(OP_TICK, -9'sd5);     // off: ignored
    send_beat(OP_START, '0);
    send_beat(OP_PAUSE, '0);
    send_beat(OP_START, '0);        // start from paused

    // Random part: four idling phases, each over several register settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle = 0;  rx_stall = 0;
        end
        1: begin
          tx_idle = 47; rx_stall = 0;
        end
        2: begin
          tx_idle = 0;  rx_stall = 47;
        end
        default: begin
          tx_idle = 29; rx_stall = 29;
        end
      endcase
      for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        case (seg)
          0: begin    // oversized count, no lingering: long sweeps that wrap at the top
            thr = 9'sd255; dwell = 16'($urandom_range(3)); cnt = 6'd63; tick_pct = 95;
          end
          1: begin    // single channel, lowest threshold
            thr = -9'sd256; dwell = 16'd0; cnt = 6'd1; tick_pct = 58;
          end
          2: begin    // full list, longest linger
            thr = 9'($urandom); dwell = 16'hFFFF; cnt = 6'd32; tick_pct = 58;
          end
          3: begin
            thr = 9'($urandom); dwell = 16'($urandom_range(4, 1));
            cnt = 6'($urandom_range(31, 2)); tick_pct = 70;
          end
          default: begin    // any count, empty and oversized included
            thr = 9'($urandom); dwell = 16'($urandom_range(6));
            cnt = 6'($urandom); tick_pct = 65;
          end
        endcase
        drain();
        write_reg(REG_THRESHOLD, {7'($urandom), thr});
        write_reg(REG_LINGER, dwell);
        write_reg(REG_COUNT, {10'($urandom), cnt});
        end_writes();
        for (int n = 0; n < BEATS_PER_SEG; n++)
          send_beat(pick_op(tick_pct, tracker.cur_mode), pick_level(tracker.threshold));
      end
    end

    // Let the last results come back, with a bound
    in_valid <= 1'b0;
    waited = 0;
    while (tracker.due.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.due.size() != 0) begin
      $error("%0d results never arrived", tracker.due.size());
      tracker.errors++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d beats, checked %0d results over 4 idling phases;",
             beats_sent, tracker.checked);
    $display("seen %0d hops, %0d wraps and %0d linger entries.",
             tracker.hops, tracker.wraps, tracker.lingers);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
